// File: rtl/core/paged_monochrome_blit_top_defines.svh
// Assertion macros used by the paged monochrome blit top.
`ifndef PAGED_MONOCHROME_BLIT_TOP_DEFINES_SVH
`define PAGED_MONOCHROME_BLIT_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PMB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PMB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/pmb_pkg.sv
// Package with the shared types and constants of the paged monochrome blit.
package pmb_pkg;

    // Default screen geometry.
    localparam int DEFAULT_COLUMNS = 128;
    localparam int DEFAULT_ROWS    = 64;

    // Request commands.
    localparam logic [1:0] CMD_BEGIN = 2'd0;
    localparam logic [1:0] CMD_PIXEL = 2'd1;
    localparam logic [1:0] CMD_FETCH = 2'd2;

    // Begin status codes.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_X_OFF = 2'd1;
    localparam logic [1:0] STATUS_Y_OFF = 2'd2;

    // Display command bytes.
    localparam logic [7:0] PAGE_CMD   = 8'h22;
    localparam logic [7:0] COLUMN_CMD = 8'h21;

    // Shift that selects a page of eight rows.
    localparam int PAGE_SHIFT = 3;

    // One result item.
    typedef struct packed {
        logic [1:0] status;
        logic [7:0] out_byte;
        logic       is_data;
        logic       last_byte;
    } res_t;

endpackage

// File: rtl/core/pmb_if.sv
// Valid/ready channel interfaces for the request and result sides.
interface pmb_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] origin_x;
    logic [7:0] origin_y;
    logic [7:0] image_width;
    logic [7:0] image_height;
    logic       pixel_on;

    modport source (output valid, cmd, origin_x, origin_y, image_width, image_height,
                    pixel_on, input ready);
    modport sink (input valid, cmd, origin_x, origin_y, image_width, image_height,
                  pixel_on, output ready);
endinterface

interface pmb_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] out_byte;
    logic       is_data;
    logic       last_byte;

    modport source (output valid, status, out_byte, is_data, last_byte, input ready);
    modport sink (input valid, status, out_byte, is_data, last_byte, output ready);
endinterface

// File: rtl/core/paged_monochrome_blit_top.sv
// A result passes from its accepting edge through the second stage registers into the output register.
// Throughput: one request per cycle while ready is high; each on-screen pixel or data fetch takes
// one frame store read followed in the next cycle by the write back or the output byte.
// Reset: control state clears at once, then a clearing pass zeroes all COLUMNS * ceil(ROWS / 8)
// frame store bytes (1024 at the default size) while ready stays low.
// Results wait in an output register with one skid entry behind it.
`include "paged_monochrome_blit_top_defines.svh"

module paged_monochrome_blit_top #(
    parameter int SCREEN_COLUMNS = pmb_pkg::DEFAULT_COLUMNS,
    parameter int SCREEN_ROWS    = pmb_pkg::DEFAULT_ROWS
) (
    input  logic     clk,
    input  logic     rst_n,
    pmb_req_if.sink  req,
    pmb_rsp_if.source rsp
);

    localparam int STORE_PAGES = (SCREEN_ROWS + 7) / 8;
    localparam int STORE_BYTES = SCREEN_COLUMNS * STORE_PAGES;
    localparam int AW          = $clog2(STORE_BYTES);
    localparam int PW          = (STORE_PAGES > 1) ? $clog2(STORE_PAGES) : 1;
    localparam int XEW         = $clog2(SCREEN_COLUMNS + 1);
    localparam int YEW         = $clog2(SCREEN_ROWS + 1);

    // Transfer phases.
    localparam logic [2:0] PH_PAGE_CMD   = 3'd0;
    localparam logic [2:0] PH_PAGE_START = 3'd1;
    localparam logic [2:0] PH_PAGE_END   = 3'd2;
    localparam logic [2:0] PH_COL_CMD    = 3'd3;
    localparam logic [2:0] PH_COL_FIRST  = 3'd4;
    localparam logic [2:0] PH_COL_LAST   = 3'd5;
    localparam logic [2:0] PH_DATA       = 3'd6;
    localparam logic [2:0] PH_DONE       = 3'd7;

    // Window and cursors.
    logic           active_reg, active_next;
    logic [7:0]     x0_reg, x0_next;
    logic [7:0]     y0_reg, y0_next;
    logic [7:0]     w_reg, w_next;
    logic [7:0]     h_reg, h_next;
    logic [XEW-1:0] x_end_reg, x_end_next;
    logic [PW-1:0]  pg_s_reg, pg_s_next;
    logic [PW-1:0]  pg_e_reg, pg_e_next;
    logic [7:0]     pcol_reg, pcol_next;
    logic [7:0]     prow_reg, prow_next;
    logic [2:0]     phase_reg, phase_next;
    logic [PW-1:0]  fpage_reg, fpage_next;
    logic [7:0]     fcol_reg, fcol_next;

    // Second stage (memory data returns).
    logic           b_res_reg, b_res_next;
    logic           b_pix_reg, b_pix_next;
    logic           b_mem_reg, b_mem_next;
    logic [AW-1:0]  b_addr_reg, b_addr_next;
    logic [7:0]     b_mask_reg, b_mask_next;
    logic           b_on_reg, b_on_next;
    pmb_pkg::res_t  b_pl_reg, b_pl_next;

    // Output register and skid entry.
    logic           o_valid_reg, o_valid_next;
    pmb_pkg::res_t  o_pl_reg, o_pl_next;
    logic           s_valid_reg, s_valid_next;
    pmb_pkg::res_t  s_pl_reg, s_pl_next;

    // Frame store port signals.
    logic           store_busy;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;
    logic [7:0]     rd_data;
    logic           wr_en;
    logic [7:0]     wr_data;

    // Request decode and combinational helpers.
    logic           accept;
    logic           in_ready;
    logic [8:0]     x_sum;
    logic [8:0]     y_sum;
    logic [XEW-1:0] x_end_new;
    logic [YEW-1:0] y_end_new;
    logic [YEW-1:0] y_last;
    logic           x_bad;
    logic           y_bad;
    logic           pix_go;
    logic [8:0]     acol;
    logic [8:0]     arow;
    logic           on_screen;
    logic [AW-1:0]  pix_addr;
    logic           pcol_wrap;
    logic           f_go;
    logic           fcol_end;
    logic           f_last;
    logic [AW-1:0]  fetch_addr;
    logic [7:0]     fetch_byte;
    logic           o_take;
    logic           o_free;
    pmb_pkg::res_t  b_pl_eff;

    pmb_frame_store #(
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (b_addr_reg),
        .wr_data (wr_data),
        .busy    (store_busy)
    );

    // The skid entry must be empty after this edge for a new request to fit.
    assign in_ready = !store_busy && !s_valid_reg && !(b_res_reg && o_valid_reg && !rsp.ready);
    assign req.ready = in_ready;
    assign accept    = req.valid && in_ready;

    // Begin: clip the rectangle and locate its pages.
    assign x_sum     = {1'b0, req.origin_x} + {1'b0, req.image_width};
    assign y_sum     = {1'b0, req.origin_y} + {1'b0, req.image_height};
    assign x_end_new = (x_sum > 9'(SCREEN_COLUMNS)) ? XEW'(SCREEN_COLUMNS) : XEW'(x_sum);
    assign y_end_new = (y_sum > 9'(SCREEN_ROWS)) ? YEW'(SCREEN_ROWS) : YEW'(y_sum);
    assign y_last    = y_end_new - YEW'(1);
    assign x_bad     = {1'b0, req.origin_x} >= 9'(SCREEN_COLUMNS);
    assign y_bad     = {1'b0, req.origin_y} >= 9'(SCREEN_ROWS);

    // Pixel: screen position of the cursor and its byte address.
    assign pix_go    = active_reg && (prow_reg < h_reg);
    assign acol      = {1'b0, x0_reg} + {1'b0, pcol_reg};
    assign arow      = {1'b0, y0_reg} + {1'b0, prow_reg};
    assign on_screen = (acol < 9'(SCREEN_COLUMNS)) && (arow < 9'(SCREEN_ROWS));
    assign pix_addr  = AW'(AW'(arow >> pmb_pkg::PAGE_SHIFT) * AW'(SCREEN_COLUMNS))
                     + AW'(acol);
    assign pcol_wrap = ({1'b0, pcol_reg} + 9'd1) >= {1'b0, w_reg};

    // Fetch: byte position within the transfer.
    assign f_go       = active_reg && (phase_reg != PH_DONE);
    assign fcol_end   = ({1'b0, fcol_reg} + 9'd1) == 9'(x_end_reg);
    assign f_last     = (phase_reg == PH_DATA) && fcol_end && (fpage_reg == pg_e_reg);
    assign fetch_addr = AW'(AW'(fpage_reg) * AW'(SCREEN_COLUMNS)) + AW'(fcol_reg);

    always_comb
    begin
        case (phase_reg)
            PH_PAGE_CMD:   fetch_byte = pmb_pkg::PAGE_CMD;
            PH_PAGE_START: fetch_byte = 8'(pg_s_reg);
            PH_PAGE_END:   fetch_byte = 8'(pg_e_reg);
            PH_COL_CMD:    fetch_byte = pmb_pkg::COLUMN_CMD;
            PH_COL_FIRST:  fetch_byte = x0_reg;
            PH_COL_LAST:   fetch_byte = 8'(x_end_reg - XEW'(1));
            default:       fetch_byte = 8'h00;
        endcase
    end

    // Memory read issue.
    assign rd_en = accept && (((req.cmd == pmb_pkg::CMD_PIXEL) && pix_go && on_screen)
                           || ((req.cmd == pmb_pkg::CMD_FETCH) && f_go
                               && (phase_reg == PH_DATA)));
    assign rd_addr = (req.cmd == pmb_pkg::CMD_PIXEL) ? pix_addr : fetch_addr;

    // Window, cursor and first stage updates.
    always_comb
    begin
        active_next = active_reg;
        x0_next     = x0_reg;
        y0_next     = y0_reg;
        w_next      = w_reg;
        h_next      = h_reg;
        x_end_next  = x_end_reg;
        pg_s_next   = pg_s_reg;
        pg_e_next   = pg_e_reg;
        pcol_next   = pcol_reg;
        prow_next   = prow_reg;
        phase_next  = phase_reg;
        fpage_next  = fpage_reg;
        fcol_next   = fcol_reg;
        b_res_next  = 1'b0;
        b_pix_next  = 1'b0;
        b_mem_next  = 1'b0;
        b_addr_next = pix_addr;
        b_mask_next = 8'b1 << arow[2:0];
        b_on_next   = req.pixel_on;
        b_pl_next   = '0;
        if (accept)
        begin
            case (req.cmd)
                pmb_pkg::CMD_BEGIN:
                begin
                    pcol_next   = '0;
                    prow_next   = '0;
                    phase_next  = PH_PAGE_CMD;
                    active_next = 1'b0;
                    b_res_next  = 1'b1;
                    if (x_bad)
                    begin
                        b_pl_next.status = pmb_pkg::STATUS_X_OFF;
                    end
                    else if (y_bad)
                    begin
                        b_pl_next.status = pmb_pkg::STATUS_Y_OFF;
                    end
                    else
                    begin
                        b_pl_next.status = pmb_pkg::STATUS_OK;
                        x0_next     = req.origin_x;
                        y0_next     = req.origin_y;
                        w_next      = req.image_width;
                        h_next      = req.image_height;
                        x_end_next  = x_end_new;
                        pg_s_next   = PW'(req.origin_y >> pmb_pkg::PAGE_SHIFT);
                        pg_e_next   = PW'(y_last >> pmb_pkg::PAGE_SHIFT);
                        fpage_next  = PW'(req.origin_y >> pmb_pkg::PAGE_SHIFT);
                        fcol_next   = req.origin_x;
                        active_next = (req.image_width != 8'd0) && (req.image_height != 8'd0);
                    end
                end
                pmb_pkg::CMD_PIXEL:
                begin
                    if (pix_go)
                    begin
                        b_pix_next = on_screen;
                        if (pcol_wrap)
                        begin
                            pcol_next = '0;
                            prow_next = prow_reg + 8'd1;
                        end
                        else
                        begin
                            pcol_next = pcol_reg + 8'd1;
                        end
                    end
                end
                pmb_pkg::CMD_FETCH:
                begin
                    if (f_go)
                    begin
                        b_res_next          = 1'b1;
                        b_mem_next          = (phase_reg == PH_DATA);
                        b_pl_next.status    = pmb_pkg::STATUS_OK;
                        b_pl_next.out_byte  = fetch_byte;
                        b_pl_next.is_data   = (phase_reg == PH_DATA);
                        b_pl_next.last_byte = f_last;
                        if (phase_reg == PH_DATA)
                        begin
                            if (f_last)
                            begin
                                phase_next = PH_DONE;
                            end
                            else if (fcol_end)
                            begin
                                fcol_next  = x0_reg;
                                fpage_next = fpage_reg + PW'(1);
                            end
                            else
                            begin
                                fcol_next = fcol_reg + 8'd1;
                            end
                        end
                        else
                        begin
                            phase_next = phase_reg + 3'd1;
                        end
                    end
                end
                default:
                begin
                    b_res_next = 1'b0;
                end
            endcase
        end
    end

    // Second stage: modify and write back, or pass the fetched byte on.
    assign wr_en   = b_pix_reg;
    assign wr_data = b_on_reg ? (rd_data | b_mask_reg) : (rd_data & ~b_mask_reg);

    always_comb
    begin
        b_pl_eff = b_pl_reg;
        if (b_mem_reg)
        begin
            b_pl_eff.out_byte = rd_data;
        end
    end

    // Output register and skid entry.
    assign o_take = o_valid_reg && rsp.ready;
    assign o_free = !o_valid_reg || o_take;

    always_comb
    begin
        o_valid_next = o_valid_reg;
        o_pl_next    = o_pl_reg;
        s_valid_next = s_valid_reg;
        s_pl_next    = s_pl_reg;
        if (s_valid_reg)
        begin
            if (o_free)
            begin
                o_valid_next = 1'b1;
                o_pl_next    = s_pl_reg;
                s_valid_next = b_res_reg;
                s_pl_next    = b_pl_eff;
            end
        end
        else if (b_res_reg)
        begin
            if (o_free)
            begin
                o_valid_next = 1'b1;
                o_pl_next    = b_pl_eff;
            end
            else
            begin
                s_valid_next = 1'b1;
                s_pl_next    = b_pl_eff;
            end
        end
        else if (o_take)
        begin
            o_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            pcol_reg    <= '0;
            prow_reg    <= '0;
            phase_reg   <= PH_PAGE_CMD;
            b_res_reg   <= 1'b0;
            b_pix_reg   <= 1'b0;
            b_mem_reg   <= 1'b0;
            o_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg  <= active_next;
            pcol_reg    <= pcol_next;
            prow_reg    <= prow_next;
            phase_reg   <= phase_next;
            b_res_reg   <= b_res_next;
            b_pix_reg   <= b_pix_next;
            b_mem_reg   <= b_mem_next;
            o_valid_reg <= o_valid_next;
            s_valid_reg <= s_valid_next;
        end
    end

    // Window bounds and payload registers.
    always_ff @(posedge clk)
    begin
        x0_reg     <= x0_next;
        y0_reg     <= y0_next;
        w_reg      <= w_next;
        h_reg      <= h_next;
        x_end_reg  <= x_end_next;
        pg_s_reg   <= pg_s_next;
        pg_e_reg   <= pg_e_next;
        fpage_reg  <= fpage_next;
        fcol_reg   <= fcol_next;
        b_addr_reg <= b_addr_next;
        b_mask_reg <= b_mask_next;
        b_on_reg   <= b_on_next;
        b_pl_reg   <= b_pl_next;
        o_pl_reg   <= o_pl_next;
        s_pl_reg   <= s_pl_next;
    end

    // Result port.
    assign rsp.valid     = o_valid_reg;
    assign rsp.status    = o_pl_reg.status;
    assign rsp.out_byte  = o_pl_reg.out_byte;
    assign rsp.is_data   = o_pl_reg.is_data;
    assign rsp.last_byte = o_pl_reg.last_byte;

    // Checks on the pipeline and the clearing pass.
    `PMB_ASSERT_NOW(a_no_accept_while_clearing, store_busy, !req.ready,
        "request accepted during the frame store clearing pass")
    `PMB_ASSERT_NOW(a_skid_has_room, s_valid_reg, !b_res_reg,
        "second stage result arrived while the skid entry was full")
    `PMB_ASSERT_NOW(a_write_in_range, b_pix_reg, 32'(b_addr_reg) < STORE_BYTES,
        "pixel write address beyond the frame store")
    `PMB_ASSERT_NEXT(a_spent_fetch_silent,
        accept && (req.cmd == pmb_pkg::CMD_FETCH) && (phase_reg == PH_DONE),
        !b_res_reg, "fetch after the final byte produced a result")

endmodule

// File: rtl/core/pmb_frame_store.sv
// Frame store memory with a clearing pass after reset and write-to-read forwarding.
module pmb_frame_store #(
    parameter int DEPTH = pmb_pkg::DEFAULT_COLUMNS * ((pmb_pkg::DEFAULT_ROWS + 7) / 8)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [7:0]               rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [7:0]               wr_data,
    output logic                     busy
);

    localparam int AW = $clog2(DEPTH);

    logic [7:0]    mem [DEPTH];
    logic [7:0]    q_reg;
    logic          clr_active_reg;
    logic          clr_active_next;
    logic [AW-1:0] clr_addr_reg;
    logic [AW-1:0] clr_addr_next;
    logic          fwd_hit_reg;
    logic          fwd_hit_next;
    logic [7:0]    fwd_data_reg;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_we;

    // Clearing pass: one entry per cycle from address zero up.
    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                clr_active_next = 1'b0;
            end
        end
    end

    // The clearing pass owns the write port while it runs.
    assign mem_we    = clr_active_reg || wr_en;
    assign mem_waddr = clr_active_reg ? clr_addr_reg : wr_addr;
    assign mem_wdata = clr_active_reg ? 8'h00 : wr_data;

    // A read of the entry being written this cycle takes the new byte.
    assign fwd_hit_next = rd_en && wr_en && (wr_addr == rd_addr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            fwd_hit_reg    <= 1'b0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            fwd_hit_reg    <= fwd_hit_next;
        end
    end

    // Memory array with a registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            q_reg <= mem[rd_addr];
        end
        fwd_data_reg <= wr_data;
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : q_reg;
    assign busy    = clr_active_reg;

endmodule
